FILE: rtl/ioc_pkg.sv
package ioc_pkg;

	localparam int unsigned DATA_W = 16;
	localparam int unsigned CAL_SAMPLES_DEF = 200;
	localparam int unsigned AXES = 3;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] accel_x_raw;
		logic signed [DATA_W-1:0] accel_y_raw;
		logic signed [DATA_W-1:0] accel_z_raw;
		logic signed [DATA_W-1:0] gyro_x_raw;
		logic signed [DATA_W-1:0] gyro_y_raw;
		logic signed [DATA_W-1:0] gyro_z_raw;
		logic                     start_gyro_cal;
		logic                     start_accel_cal;
	} ioc_sample_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] accel_x_out;
		logic signed [DATA_W-1:0] accel_y_out;
		logic signed [DATA_W-1:0] accel_z_out;
		logic signed [DATA_W-1:0] gyro_x_out;
		logic signed [DATA_W-1:0] gyro_y_out;
		logic signed [DATA_W-1:0] gyro_z_out;
		logic                     gyro_cal_busy;
		logic                     accel_cal_busy;
		logic                     gyro_cal_done;
		logic                     accel_cal_done;
	} ioc_result_t;

	// Reading minus offset, clamped to the signed range of a reading.
	function automatic logic signed [DATA_W-1:0] sat_sub(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		logic [DATA_W:0] d;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (d[DATA_W] != d[DATA_W-1]) begin
			return d[DATA_W] ? SAT_MIN : SAT_MAX;
		end
		return signed'(d[DATA_W-1:0]);
	endfunction

endpackage

FILE: rtl/ioc_if.sv
interface ioc_sample_if import ioc_pkg::*; ();
	logic        valid;
	logic        ready;
	ioc_sample_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ioc_result_if import ioc_pkg::*; ();
	logic        valid;
	logic        ready;
	ioc_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ioc_div.sv
module ioc_div import ioc_pkg::*; #(
	parameter int unsigned CAL_SAMPLES = CAL_SAMPLES_DEF,
	parameter int unsigned SUM_W = DATA_W + $clog2(CAL_SAMPLES)
) (
	input  logic signed [SUM_W-1:0]  dividend [AXES],
	output logic signed [DATA_W-1:0] quotient [AXES]
);

	// Magnitude times a rounded-up reciprocal; exact for every magnitude below 2**SUM_W.
	localparam int unsigned K = SUM_W + $clog2(CAL_SAMPLES);
	localparam int unsigned PROD_W = 2 * SUM_W + 1;
	localparam int unsigned QW = PROD_W - K;
	localparam longint unsigned MultFull =
		((64'd1 << K) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
	localparam logic [SUM_W:0] Mult = MultFull[SUM_W:0];

	for (genvar l = 0; l < AXES; l++) begin : g_lane
		logic              neg;
		logic [SUM_W-1:0]  mag;
		logic [PROD_W-1:0] prod;
		logic [QW-1:0]     qmag;
		logic [QW-1:0]     qs;

		assign neg = dividend[l][SUM_W-1];
		assign mag = neg ? (~unsigned'(dividend[l]) + 1'b1) : unsigned'(dividend[l]);
		assign prod = PROD_W'(mag) * PROD_W'(Mult);
		assign qmag = prod[K +: QW];
		assign qs = neg ? (~qmag + 1'b1) : qmag;
		assign quotient[l] = signed'(qs[DATA_W-1:0]);
	end

endmodule

FILE: rtl/imu_offset_calibration.sv
// A sample passes through the input register, the calibration control stage and the
// offset subtraction into the result register.
// Throughput: one sample per cycle; a stalled result holds the whole pipeline.
// Reset clears offsets, sums, sample counts, calibration flags and pipeline valids;
// offsets read as zero until a calibration completes.
module imu_offset_calibration import ioc_pkg::*; #(
	parameter int unsigned CAL_SAMPLES = CAL_SAMPLES_DEF
) (
	input logic            clk,
	input logic            arst_n,
	ioc_sample_if.sink     sensor,
	ioc_result_if.source   corrected
);

	localparam int unsigned SumW = DATA_W + $clog2(CAL_SAMPLES);
	localparam int unsigned CntW = $clog2(CAL_SAMPLES + 1);
	localparam logic [CntW-1:0] CntLast = CntW'(CAL_SAMPLES);

	typedef logic signed [SumW-1:0] sum_t;

	typedef struct packed {
		logic gyro_busy;
		logic accel_busy;
		logic gyro_done;
		logic accel_done;
		logic gyro_clr;
		logic accel_clr;
	} cal_flags_t;

	logic en;

	logic        valid_s1;
	ioc_sample_t smp_s1;

	logic        valid_s2;
	ioc_sample_t smp_s2;
	cal_flags_t  flags_s2;
	sum_t        div_sum_s2 [AXES];

	logic signed [DATA_W-1:0] gyro_off_q [AXES];
	logic signed [DATA_W-1:0] accel_off_q [AXES];
	sum_t                     gyro_sum_q [AXES];
	sum_t                     accel_sum_q [2];
	logic [CntW-1:0]          gyro_cnt_q;
	logic [CntW-1:0]          accel_cnt_q;
	logic                     gyro_act_q;
	logic                     accel_act_q;

	sum_t            gyro_raw [AXES];
	sum_t            accel_raw [2];
	sum_t            gyro_sum_n [AXES];
	sum_t            accel_sum_n [2];
	logic [CntW-1:0] gyro_cnt_n;
	logic [CntW-1:0] accel_cnt_n;
	logic            gyro_arm;
	logic            accel_arm;
	logic            skip_accel;
	cal_flags_t      flags_n;
	sum_t            div_sum_n [AXES];

	logic signed [DATA_W-1:0] quot [AXES];

	assign en = !corrected.valid || corrected.ready;
	assign sensor.ready = en;

	assign gyro_raw[0] = SumW'(smp_s1.gyro_x_raw);
	assign gyro_raw[1] = SumW'(smp_s1.gyro_y_raw);
	assign gyro_raw[2] = SumW'(smp_s1.gyro_z_raw);
	assign accel_raw[0] = SumW'(smp_s1.accel_x_raw);
	assign accel_raw[1] = SumW'(smp_s1.accel_y_raw);

	// While a sensor accumulates its offsets are zero, so the sums take the raw readings.
	always_comb begin
		gyro_arm = gyro_act_q || smp_s1.start_gyro_cal;
		accel_arm = accel_act_q || smp_s1.start_accel_cal;
		gyro_sum_n = gyro_sum_q;
		accel_sum_n = accel_sum_q;
		gyro_cnt_n = gyro_cnt_q;
		accel_cnt_n = accel_cnt_q;
		skip_accel = 1'b0;
		flags_n = '0;
		flags_n.gyro_busy = gyro_arm;
		flags_n.accel_busy = accel_arm;

		if (gyro_arm) begin
			if (gyro_cnt_q == '0) begin
				for (int i = 0; i < AXES; i++) begin
					gyro_sum_n[i] = '0;
				end
				gyro_cnt_n = CntW'(1);
				flags_n.gyro_clr = 1'b1;
				skip_accel = 1'b1;
			end else begin
				for (int i = 0; i < AXES; i++) begin
					gyro_sum_n[i] = gyro_sum_q[i] + gyro_raw[i];
				end
				if (gyro_cnt_q == CntLast) begin
					gyro_cnt_n = '0;
					flags_n.gyro_busy = 1'b0;
					flags_n.gyro_done = 1'b1;
					skip_accel = 1'b1;
				end else begin
					gyro_cnt_n = gyro_cnt_q + 1'b1;
				end
			end
		end

		if (accel_arm && !skip_accel) begin
			if (accel_cnt_q == '0) begin
				accel_sum_n[0] = '0;
				accel_sum_n[1] = '0;
				accel_cnt_n = CntW'(1);
				flags_n.accel_clr = 1'b1;
			end else begin
				accel_sum_n[0] = accel_sum_q[0] + accel_raw[0];
				accel_sum_n[1] = accel_sum_q[1] + accel_raw[1];
				if (accel_cnt_q == CntLast) begin
					accel_cnt_n = '0;
					flags_n.accel_busy = 1'b0;
					flags_n.accel_done = 1'b1;
				end else begin
					accel_cnt_n = accel_cnt_q + 1'b1;
				end
			end
		end

		if (flags_n.gyro_done) begin
			div_sum_n = gyro_sum_n;
		end else begin
			div_sum_n[0] = accel_sum_n[0];
			div_sum_n[1] = accel_sum_n[1];
			div_sum_n[2] = '0;
		end
	end

	ioc_div #(
		.CAL_SAMPLES (CAL_SAMPLES),
		.SUM_W       (SumW)
	) u_div (
		.dividend (div_sum_s2),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			corrected.valid <= 1'b0;
			gyro_cnt_q <= '0;
			accel_cnt_q <= '0;
			gyro_act_q <= 1'b0;
			accel_act_q <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				gyro_off_q[i] <= '0;
				accel_off_q[i] <= '0;
				gyro_sum_q[i] <= '0;
			end
			accel_sum_q[0] <= '0;
			accel_sum_q[1] <= '0;
		end else if (en) begin
			valid_s1 <= sensor.valid;
			valid_s2 <= valid_s1;
			corrected.valid <= valid_s2;
			if (valid_s1) begin
				gyro_sum_q <= gyro_sum_n;
				accel_sum_q <= accel_sum_n;
				gyro_cnt_q <= gyro_cnt_n;
				accel_cnt_q <= accel_cnt_n;
				gyro_act_q <= flags_n.gyro_busy;
				accel_act_q <= flags_n.accel_busy;
			end
			// Offset changes take effect once the sample that caused them has been corrected.
			if (valid_s2) begin
				for (int i = 0; i < AXES; i++) begin
					if (flags_s2.gyro_clr) begin
						gyro_off_q[i] <= '0;
					end else if (flags_s2.gyro_done) begin
						gyro_off_q[i] <= quot[i];
					end
				end
				if (flags_s2.accel_clr) begin
					for (int i = 0; i < AXES; i++) begin
						accel_off_q[i] <= '0;
					end
				end else if (flags_s2.accel_done) begin
					accel_off_q[0] <= quot[0];
					accel_off_q[1] <= quot[1];
					accel_off_q[2] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smp_s1 <= sensor.data;
			smp_s2 <= smp_s1;
			flags_s2 <= flags_n;
			div_sum_s2 <= div_sum_n;
			corrected.data.accel_x_out <= sat_sub(smp_s2.accel_x_raw, accel_off_q[0]);
			corrected.data.accel_y_out <= sat_sub(smp_s2.accel_y_raw, accel_off_q[1]);
			corrected.data.accel_z_out <= sat_sub(smp_s2.accel_z_raw, accel_off_q[2]);
			corrected.data.gyro_x_out <= sat_sub(smp_s2.gyro_x_raw, gyro_off_q[0]);
			corrected.data.gyro_y_out <= sat_sub(smp_s2.gyro_y_raw, gyro_off_q[1]);
			corrected.data.gyro_z_out <= sat_sub(smp_s2.gyro_z_raw, gyro_off_q[2]);
			corrected.data.gyro_cal_busy <= flags_s2.gyro_busy;
			corrected.data.accel_cal_busy <= flags_s2.accel_busy;
			corrected.data.gyro_cal_done <= flags_s2.gyro_done;
			corrected.data.accel_cal_done <= flags_s2.accel_done;
		end
	end

endmodule

FILE: rtl/ioc_checker.sv
module ioc_checker import ioc_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	ioc_sample_if.sink   sensor,
	ioc_result_if.source corrected
);

	// The gyro calibration holds the accelerometer back on its final sample.
	a_done_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		corrected.valid |->
			!(corrected.data.gyro_cal_done && corrected.data.accel_cal_done))
		else $error("both calibrations completed in one transaction");

	a_gyro_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		corrected.valid && corrected.data.gyro_cal_done |-> !corrected.data.gyro_cal_busy)
		else $error("gyro calibration still busy after completing");

	a_accel_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		corrected.valid && corrected.data.accel_cal_done |-> !corrected.data.accel_cal_busy)
		else $error("accelerometer calibration still busy after completing");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!corrected.valid |-> sensor.ready)
		else $error("input refused while the result register is empty");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		corrected.valid && !corrected.ready |=> corrected.valid && $stable(corrected.data))
		else $error("stalled result changed");

endmodule

bind imu_offset_calibration ioc_checker u_ioc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.sensor    (sensor),
	.corrected (corrected)
);

FILE: dv/tb_imu_offset_calibration.sv
module tb_imu_offset_calibration import ioc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAL_N = 200;
	localparam int SUM_W = 24;
	localparam int RANDOM_SAMPLES = 1834;
	localparam int DRAIN_CYCLES = 12;
	localparam int LIMIT_CYCLES = 400000;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		ioc_sample_t smp;
		bit          typed;
		ioc_result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	ioc_sample_if sensor_if ();
	ioc_result_if result_if ();

	imu_offset_calibration #(
		.CAL_SAMPLES(CAL_N)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sensor   (sensor_if),
		.corrected(result_if)
	);

	logic signed [DATA_W-1:0] gyro_ofs [AXES] = '{default: '0};
	logic signed [DATA_W-1:0] accel_ofs [AXES] = '{default: '0};
	logic signed [SUM_W-1:0]  gyro_sum [AXES] = '{default: '0};
	logic signed [SUM_W-1:0]  accel_sum [2] = '{default: '0};
	logic [8:0]               gyro_cnt = '0;
	logic [8:0]               accel_cnt = '0;
	bit                       gyro_run = 1'b0;
	bit                       accel_run = 1'b0;

	ioc_result_t expected_results [$];
	stim_row_t   stim_table [$];
	int          axis_centre [6];
	int          mismatches = 0;
	int          results_seen = 0;

	function automatic logic signed [DATA_W-1:0] clamp16(input int v);
		if (v > int'(SAT_MAX)) begin
			return SAT_MAX;
		end
		if (v < int'(SAT_MIN)) begin
			return SAT_MIN;
		end
		return DATA_W'(v);
	endfunction

	function automatic ioc_sample_t mk_sample(input int ax, input int ay, input int az,
			input int gx, input int gy, input int gz, input bit sg, input bit sa);
		ioc_sample_t s;
		s.accel_x_raw = DATA_W'(ax);
		s.accel_y_raw = DATA_W'(ay);
		s.accel_z_raw = DATA_W'(az);
		s.gyro_x_raw = DATA_W'(gx);
		s.gyro_y_raw = DATA_W'(gy);
		s.gyro_z_raw = DATA_W'(gz);
		s.start_gyro_cal = sg;
		s.start_accel_cal = sa;
		return s;
	endfunction

	function automatic ioc_result_t mk_result(input int ax, input int ay, input int az,
			input int gx, input int gy, input int gz, input bit gb, input bit ab,
			input bit gd, input bit ad);
		ioc_result_t r;
		r.accel_x_out = DATA_W'(ax);
		r.accel_y_out = DATA_W'(ay);
		r.accel_z_out = DATA_W'(az);
		r.gyro_x_out = DATA_W'(gx);
		r.gyro_y_out = DATA_W'(gy);
		r.gyro_z_out = DATA_W'(gz);
		r.gyro_cal_busy = gb;
		r.accel_cal_busy = ab;
		r.gyro_cal_done = gd;
		r.accel_cal_done = ad;
		return r;
	endfunction

	// Offset correction and calibration bookkeeping for one accepted sample.
	function automatic ioc_result_t correct_sample(input ioc_sample_t s);
		ioc_result_t              r;
		logic signed [DATA_W-1:0] raw_a [AXES];
		logic signed [DATA_W-1:0] raw_g [AXES];
		logic signed [DATA_W-1:0] acc [AXES];
		logic signed [DATA_W-1:0] gyr [AXES];
		bit                       g_done;
		bit                       a_done;
		bit                       hold_accel;
		g_done = 1'b0;
		a_done = 1'b0;
		hold_accel = 1'b0;
		raw_a = '{s.accel_x_raw, s.accel_y_raw, s.accel_z_raw};
		raw_g = '{s.gyro_x_raw, s.gyro_y_raw, s.gyro_z_raw};
		if (s.start_gyro_cal) begin
			gyro_run = 1'b1;
		end
		if (s.start_accel_cal) begin
			accel_run = 1'b1;
		end
		for (int i = 0; i < AXES; i++) begin
			acc[i] = clamp16(int'(raw_a[i]) - int'(accel_ofs[i]));
			gyr[i] = clamp16(int'(raw_g[i]) - int'(gyro_ofs[i]));
		end
		if (gyro_run) begin
			if (gyro_cnt == 0) begin
				for (int i = 0; i < AXES; i++) begin
					gyro_ofs[i] = '0;
					gyro_sum[i] = '0;
				end
				gyro_cnt = 9'd1;
				hold_accel = 1'b1;
			end else begin
				for (int i = 0; i < AXES; i++) begin
					gyro_sum[i] = SUM_W'(int'(gyro_sum[i]) + int'(gyr[i]));
				end
				if (gyro_cnt >= CAL_N) begin
					for (int i = 0; i < AXES; i++) begin
						gyro_ofs[i] = DATA_W'(int'(gyro_sum[i]) / CAL_N);
					end
					gyro_cnt = '0;
					gyro_run = 1'b0;
					g_done = 1'b1;
					hold_accel = 1'b1;
				end else begin
					gyro_cnt++;
				end
			end
		end
		if (accel_run && !hold_accel) begin
			if (accel_cnt == 0) begin
				for (int i = 0; i < AXES; i++) begin
					accel_ofs[i] = '0;
				end
				accel_sum[0] = '0;
				accel_sum[1] = '0;
				accel_cnt = 9'd1;
			end else begin
				for (int i = 0; i < 2; i++) begin
					accel_sum[i] = SUM_W'(int'(accel_sum[i]) + int'(acc[i]));
				end
				if (accel_cnt >= CAL_N) begin
					for (int i = 0; i < 2; i++) begin
						accel_ofs[i] = DATA_W'(int'(accel_sum[i]) / CAL_N);
					end
					accel_ofs[2] = '0;
					accel_cnt = '0;
					accel_run = 1'b0;
					a_done = 1'b1;
				end else begin
					accel_cnt++;
				end
			end
		end
		r.accel_x_out = acc[0];
		r.accel_y_out = acc[1];
		r.accel_z_out = acc[2];
		r.gyro_x_out = gyr[0];
		r.gyro_y_out = gyr[1];
		r.gyro_z_out = gyr[2];
		r.gyro_cal_busy = gyro_run;
		r.accel_cal_busy = accel_run;
		r.gyro_cal_done = g_done;
		r.accel_cal_done = a_done;
		return r;
	endfunction

	function automatic void cmp_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("result %0d, %s: expected %0d, got %0d", results_seen, name, want,
					got);
			end
		end
	endfunction

	function automatic void check_result(input ioc_result_t got);
		ioc_result_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("result %0d arrived with no sample outstanding", results_seen);
			end
		end else begin
			want = expected_results.pop_front();
			cmp_field("accel_x_out", 32'(want.accel_x_out), 32'(got.accel_x_out));
			cmp_field("accel_y_out", 32'(want.accel_y_out), 32'(got.accel_y_out));
			cmp_field("accel_z_out", 32'(want.accel_z_out), 32'(got.accel_z_out));
			cmp_field("gyro_x_out", 32'(want.gyro_x_out), 32'(got.gyro_x_out));
			cmp_field("gyro_y_out", 32'(want.gyro_y_out), 32'(got.gyro_y_out));
			cmp_field("gyro_z_out", 32'(want.gyro_z_out), 32'(got.gyro_z_out));
			cmp_field("gyro_cal_busy", 32'(want.gyro_cal_busy), 32'(got.gyro_cal_busy));
			cmp_field("accel_cal_busy", 32'(want.accel_cal_busy),
				32'(got.accel_cal_busy));
			cmp_field("gyro_cal_done", 32'(want.gyro_cal_done), 32'(got.gyro_cal_done));
			cmp_field("accel_cal_done", 32'(want.accel_cal_done),
				32'(got.accel_cal_done));
		end
		results_seen++;
	endfunction

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 4));
	endfunction

	// Mostly a steady reading around a per-axis bias, as a sensor at rest would give.
	function automatic int draw_reading(input int centre);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			return int'(clamp16(centre + int'($urandom_range(0, 128)) - 64));
		end
		if (pick < 82) begin
			return int'($urandom_range(0, 65535));
		end
		if (pick < 92) begin
			case ($urandom_range(0, 2))
				0: begin
					return int'(SAT_MAX);
				end
				1: begin
					return int'(SAT_MIN);
				end
				default: begin
					return 0;
				end
			endcase
		end
		return int'(clamp16(centre + int'($urandom_range(0, 8192)) - 4096));
	endfunction

	function automatic void draw_centres();
		for (int i = 0; i < 6; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				axis_centre[i] = int'($urandom_range(0, 60000)) - 30000;
			end else begin
				axis_centre[i] = int'($urandom_range(0, 4000)) - 2000;
			end
		end
	endfunction

	function automatic void add_row(input ioc_sample_t s, input bit typed,
			input ioc_result_t r);
		stim_row_t row;
		row.smp = s;
		row.typed = typed;
		row.res = r;
		stim_table.push_back(row);
	endfunction

	task automatic send_sample(input ioc_sample_t s, input bit typed, input ioc_result_t r,
			input bit calm);
		int          gap;
		ioc_result_t predicted;
		gap = draw_wait(calm);
		if (gap > 0) begin
			sensor_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sensor_if.valid <= 1'b1;
		sensor_if.data <= s;
		do @(posedge clk); while (sensor_if.ready !== 1'b1);
		predicted = correct_sample(s);
		expected_results.push_back(typed ? r : predicted);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_imu_offset_calibration failed");
		$finish;
	end

	initial begin : result_sink
		int stall;
		int taken;
		taken = 0;
		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = draw_wait(((taken / 170) % 3) == 1);
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (result_if.valid !== 1'b1);
			check_result(result_if.data);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : sample_source
		ioc_sample_t s;
		ioc_result_t none;
		none = '0;
		arst_n = 1'b0;
		sensor_if.valid = 1'b0;
		sensor_if.data = '0;

		// With zero offsets every reading passes through unchanged.
		add_row(mk_sample(0, 0, 0, 0, 0, 0, 0, 0), 1,
			mk_result(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk_sample(32767, 32767, 32767, 32767, 32767, 32767, 0, 0), 1,
			mk_result(32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0, 0));
		add_row(mk_sample(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0), 1,
			mk_result(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0, 0));
		add_row(mk_sample(32767, -32768, 1, -1, 21845, -21846, 0, 0), 1,
			mk_result(32767, -32768, 1, -1, 21845, -21846, 0, 0, 0, 0));
		add_row(mk_sample(-1, 1, -32768, 32767, -21846, 21845, 0, 0), 1,
			mk_result(-1, 1, -32768, 32767, -21846, 21845, 0, 0, 0, 0));
		// Both starts together: the gyro clearing transaction holds the accelerometer back.
		add_row(mk_sample(100, -200, 300, -400, 500, -600, 1, 1), 1,
			mk_result(100, -200, 300, -400, 500, -600, 1, 1, 0, 0));
		add_row(mk_sample(10, 20, 30, 40, 50, 60, 0, 0), 1,
			mk_result(10, 20, 30, 40, 50, 60, 1, 1, 0, 0));
		// A start while already calibrating changes nothing.
		add_row(mk_sample(-7, -8, -9, 7, 8, 9, 1, 0), 1,
			mk_result(-7, -8, -9, 7, 8, 9, 1, 1, 0, 0));
		add_row(mk_sample(-32768, 32767, 0, -32768, 32767, 0, 0, 1), 1,
			mk_result(-32768, 32767, 0, -32768, 32767, 0, 1, 1, 0, 0));
		add_row(mk_sample(32767, 32767, 32767, 32767, 32767, 32767, 1, 1), 0, none);
		add_row(mk_sample(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0), 0, none);
		add_row(mk_sample(12345, -12345, 4096, -4096, 255, -256, 0, 0), 0, none);
		add_row(mk_sample(1, 2, 3, -3, -2, -1, 0, 1), 0, none);
		add_row(mk_sample(-32767, 32766, -2, 2, -32767, 32766, 1, 0), 0, none);
		add_row(mk_sample(0, 0, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(mk_sample(21845, -21846, 21845, -21846, 21845, -21846, 0, 0), 0, none);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_table[i]) begin
			send_sample(stim_table[i].smp, stim_table[i].typed, stim_table[i].res, 1'b0);
		end

		for (int n = 0; n < RANDOM_SAMPLES; n++) begin
			if (n % 200 == 0) begin
				draw_centres();
			end
			s = mk_sample(draw_reading(axis_centre[0]), draw_reading(axis_centre[1]),
				draw_reading(axis_centre[2]), draw_reading(axis_centre[3]),
				draw_reading(axis_centre[4]), draw_reading(axis_centre[5]),
				$urandom_range(0, 99) < 3, $urandom_range(0, 99) < 3);
			send_sample(s, 1'b0, none, ((n / 150) % 3) == 2);
		end
		sensor_if.valid <= 1'b0;

		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("tb_imu_offset_calibration passed");
		end else begin
			$display("tb_imu_offset_calibration failed");
		end
		$finish;
	end

endmodule
